// ===== rtl/core/hgsp_pkg.sv =====
// Shared types, codes and weight tables of the height grid shortest path block.
package hgsp_pkg;

   localparam int GRID_SIDE = 8;
   localparam int HEIGHT_BITS = 8;
   localparam int COORD_W = 3;
   localparam int NODE_W = 6;
   localparam int NODE_COUNT = 64;
   localparam int DIST_W = 24;
   localparam int WEIGHT_W = 17;
   localparam int DH_W = 8;
   localparam int DH_COUNT = 256;
   localparam int ROUTE_CNT_W = 7;

   typedef enum logic [2:0] {
      CMD_CREATE      = 3'd0,
      CMD_SET_HEIGHT  = 3'd1,
      CMD_FLATTEN     = 3'd2,
      CMD_FLATTEN_ALL = 3'd3,
      CMD_ADD_EDGE    = 3'd4,
      CMD_QUERY       = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_EXISTS   = 3'd1,
      STATUS_ABSENT   = 3'd2,
      STATUS_FULL     = 3'd3,
      STATUS_NO_PATH  = 3'd4,
      STATUS_BAD_KIND = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      KIND_WALL = 2'd0,
      KIND_DIAG = 2'd1,
      KIND_ARC  = 2'd2,
      KIND_BAD  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      POP_NONE,
      POP_WRITE,
      POP_FLAT,
      POP_FLAT_ALL
   } point_op_type;

   typedef struct packed {
      point_op_type      op;
      logic [NODE_W-1:0] addr;
   } point_ctl_type;

   typedef struct packed {
      logic [NODE_W-1:0]   a;
      logic [NODE_W-1:0]   b;
      logic [WEIGHT_W-1:0] weight;
   } edge_entry_type;

   typedef struct packed {
      logic [DIST_W-1:0] cost;
      logic [NODE_W-1:0] pred;
   } node_entry_type;

   typedef logic [DH_COUNT-1:0][WEIGHT_W-1:0] weight_table_type;

   // One plus the rounded diagonal length, both scaled by 256.
   function automatic weight_table_type build_diag_table();
      weight_table_type t;
      longint unsigned n;
      longint unsigned r;
      longint unsigned c;
      t = '0;
      for (int d = 0; d < DH_COUNT; d++) begin
         n = 64'd65536 * (64'd1 + 64'(d) * 64'(d));
         r = 64'd0;
         for (int k = 31; k >= 0; k--) begin
            c = r | (64'd1 << k);
            if (c * c <= n) begin
               r = c;
            end
         end
         if (n - r * r > r) begin
            r = r + 64'd1;
         end
         t[d] = WEIGHT_W'(64'd256 + r);
      end
      return t;
   endfunction

   // Quarter circle arc over a height step, scaled by 256, rounded half up.
   function automatic weight_table_type build_arc_table();
      weight_table_type t;
      t = '0;
      for (int d = 0; d < DH_COUNT; d++) begin
         t[d] = WEIGHT_W'((64'd4021238528 * 64'(d + 1) + 64'd5000000) / 64'd10000000);
      end
      return t;
   endfunction

   localparam weight_table_type DIAG_TABLE = build_diag_table();
   localparam weight_table_type ARC_TABLE = build_arc_table();

endpackage

// ===== rtl/core/height_grid_shortest_path.sv =====
// Top level of the height grid shortest path block: command sequencer and search engine.
//
// The block keeps an 8 x 8 window of a grid of points (each absent or holding a height) and an
// edge table, and answers shortest path queries with a Dijkstra search. Items are taken one at
// a time: req_tready is high only while the sequencer is idle, but a finished result may still
// wait in the output register while the next item is accepted. Create, set height, flatten and
// flatten all go from the execute state straight to the result state; adding an edge also passes
// two height states, since the two heights come out of the single height memory port one
// after the other, and the weight is then computed from the height step or looked up in
// constant tables. A query writes the start node, then per settled node runs one scan pass
// over the node memory to find the next node and one pass over the edge table, with an extra
// node update step for every edge that touches the settled node, since every edge and every
// node update goes through one read port. The path is then traced back and sent node by node.
// Search state (reached, settled and predecessor flags) sits in flip-flops cleared at the start
// of each query, so there is no clearing pass.
module height_grid_shortest_path
   import hgsp_pkg::*;
#(
   parameter int MAX_EDGES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // first_x[2:0], first_y[5:3], second_x[8:6], second_y[11:9], new_height[19:12],
   // edge_kind[21:20], zero fill[23:22]
   input  logic [23:0] req_tdata,
   // cmd[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // node_x[2:0], node_y[5:3], total_distance[29:6], zero fill[31:30]
   output logic [31:0] rsp_tdata,
   // status[2:0]
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int EIDX_W = $clog2(MAX_EDGES);
   localparam int CNT_W = $clog2(MAX_EDGES + 1);
   localparam logic [5:0] SIDE_LIMIT = 6'(GRID_SIDE);
   localparam logic [CNT_W-1:0] EDGE_LIMIT = CNT_W'(MAX_EDGES);
   localparam logic [ROUTE_CNT_W-1:0] SCAN_END = ROUTE_CNT_W'(NODE_COUNT);
   localparam logic [ROUTE_CNT_W-1:0] ROUTE_LAST = ROUTE_CNT_W'(NODE_COUNT - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_HEIGHT_A,
      S_HEIGHT_B,
      S_SCAN,
      S_EDGE_RD,
      S_EDGE_CHK,
      S_NODE_UPD,
      S_WALK_RD,
      S_WALK_NEXT,
      S_EMIT_RD,
      S_EMIT_LD,
      S_RESP
   } state_type;

   state_type                  state_ff, state_in;
   logic [2:0]                 cmd_ff, cmd_in;
   logic [NODE_W-1:0]          p_ff, p_in;
   logic [NODE_W-1:0]          q_ff, q_in;
   logic                       first_ok_ff, first_ok_in;
   logic                       second_ok_ff, second_ok_in;
   logic [HEIGHT_BITS-1:0]     nh_ff, nh_in;
   logic [1:0]                 kind_ff, kind_in;
   logic [2:0]                 status_ff, status_in;
   logic [HEIGHT_BITS-1:0]     ha_ff, ha_in;
   logic [NODE_COUNT-1:0]      reached_ff, reached_in;
   logic [NODE_COUNT-1:0]      settled_ff, settled_in;
   logic [NODE_COUNT-1:0]      haspred_ff, haspred_in;
   logic [ROUTE_CNT_W-1:0]     scan_cnt_ff, scan_cnt_in;
   logic                       pend_ff, pend_in;
   logic [NODE_W-1:0]          pend_idx_ff, pend_idx_in;
   logic                       found_ff, found_in;
   logic [DIST_W-1:0]          min_dist_ff, min_dist_in;
   logic [NODE_W-1:0]          min_idx_ff, min_idx_in;
   logic [CNT_W-1:0]           eidx_ff, eidx_in;
   logic [NODE_W-1:0]          v_ff, v_in;
   logic [NODE_W-1:0]          walk_cur_ff, walk_cur_in;
   logic [ROUTE_CNT_W-1:0]     route_n_ff, route_n_in;
   logic [DIST_W-1:0]          goal_dist_ff, goal_dist_in;
   logic [NODE_W-1:0]          ridx_ff, ridx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [2:0]                 rsp_status_ff, rsp_status_in;
   logic [NODE_W-1:0]          rsp_node_ff, rsp_node_in;
   logic [DIST_W-1:0]          rsp_dist_ff, rsp_dist_in;
   logic                       rsp_last_ff, rsp_last_in;

   point_ctl_type              point_ctl;
   logic [HEIGHT_BITS-1:0]     point_wheight;
   logic [NODE_W-1:0]          point_raddr;
   logic [HEIGHT_BITS-1:0]     point_rheight;
   logic [NODE_COUNT-1:0]      point_present;

   logic                       edge_append;
   edge_entry_type             edge_entry;
   edge_entry_type             edge_q;
   logic [CNT_W-1:0]           edge_count;

   logic                       node_we;
   logic [NODE_W-1:0]          node_waddr;
   node_entry_type             node_wdata;
   logic [NODE_W-1:0]          node_raddr;
   node_entry_type             node_q;

   logic                       route_we;
   logic [NODE_W-1:0]          route_mem [NODE_COUNT];
   logic [NODE_W-1:0]          route_q_ff;

   logic [COORD_W-1:0]         in_fx, in_fy, in_sx, in_sy;
   logic                       rsp_free;
   logic                       pair_ok;
   logic                       cand;
   logic [HEIGHT_BITS-1:0]     dh;
   logic [DH_W-1:0]            dh8;
   logic [WEIGHT_W-1:0]        weight;
   logic                       hit_a, hit_b;
   logic [NODE_W-1:0]          v_sel;
   logic [DIST_W:0]            dist_sum;
   logic [DIST_W-1:0]          new_dist;
   logic [CNT_W-1:0]           eidx_next;

   assign in_fx = req_tdata[2:0];
   assign in_fy = req_tdata[5:3];
   assign in_sx = req_tdata[8:6];
   assign in_sy = req_tdata[11:9];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign pair_ok = first_ok_ff && second_ok_ff && point_present[p_ff] && point_present[q_ff];

   assign cand = reached_ff[pend_idx_ff] && !settled_ff[pend_idx_ff];
   assign dh = (ha_ff > point_rheight) ? (ha_ff - point_rheight) : (point_rheight - ha_ff);
   assign dh8 = DH_W'(dh);
   assign hit_a = (edge_q.a == min_idx_ff);
   assign hit_b = (edge_q.b == min_idx_ff);
   assign v_sel = hit_a ? edge_q.b : edge_q.a;
   assign dist_sum = {1'b0, min_dist_ff} + (DIST_W + 1)'(edge_q.weight);
   assign new_dist = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
   assign eidx_next = eidx_ff + 1'b1;

   always_comb begin
      case (kind_ff)
         KIND_WALL: weight = WEIGHT_W'({({1'b0, dh8} + 9'd1), 8'd0});
         KIND_DIAG: weight = DIAG_TABLE[dh8];
         KIND_ARC:  weight = ARC_TABLE[dh8];
         default:   weight = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      p_in = p_ff;
      q_in = q_ff;
      first_ok_in = first_ok_ff;
      second_ok_in = second_ok_ff;
      nh_in = nh_ff;
      kind_in = kind_ff;
      status_in = status_ff;
      ha_in = ha_ff;
      reached_in = reached_ff;
      settled_in = settled_ff;
      haspred_in = haspred_ff;
      scan_cnt_in = scan_cnt_ff;
      pend_in = pend_ff;
      pend_idx_in = pend_idx_ff;
      found_in = found_ff;
      min_dist_in = min_dist_ff;
      min_idx_in = min_idx_ff;
      eidx_in = eidx_ff;
      v_in = v_ff;
      walk_cur_in = walk_cur_ff;
      route_n_in = route_n_ff;
      goal_dist_in = goal_dist_ff;
      ridx_in = ridx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_node_in = rsp_node_ff;
      rsp_dist_in = rsp_dist_ff;
      rsp_last_in = rsp_last_ff;

      point_ctl.op = POP_NONE;
      point_ctl.addr = p_ff;
      point_wheight = nh_ff;
      point_raddr = p_ff;
      edge_append = 1'b0;
      edge_entry.a = p_ff;
      edge_entry.b = q_ff;
      edge_entry.weight = weight;
      node_we = 1'b0;
      node_waddr = v_ff;
      node_wdata.cost = new_dist;
      node_wdata.pred = min_idx_ff;
      node_raddr = walk_cur_ff;
      route_we = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tuser;
               p_in = {in_fx, in_fy};
               q_in = {in_sx, in_sy};
               first_ok_in = ({3'b000, in_fx} < SIDE_LIMIT) && ({3'b000, in_fy} < SIDE_LIMIT);
               second_ok_in = ({3'b000, in_sx} < SIDE_LIMIT) && ({3'b000, in_sy} < SIDE_LIMIT);
               nh_in = HEIGHT_BITS'(req_tdata[19:12]);
               kind_in = req_tdata[21:20];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = STATUS_OK;
            state_in = S_RESP;
            unique case (cmd_ff)
               CMD_CREATE: begin
                  if (!first_ok_ff) begin
                     status_in = STATUS_ABSENT;
                  end else if (point_present[p_ff]) begin
                     status_in = STATUS_EXISTS;
                  end else begin
                     point_ctl.op = POP_WRITE;
                  end
               end
               CMD_SET_HEIGHT: begin
                  if (!first_ok_ff) begin
                     status_in = STATUS_ABSENT;
                  end else begin
                     point_ctl.op = POP_WRITE;
                  end
               end
               CMD_FLATTEN: begin
                  if (!first_ok_ff) begin
                     status_in = STATUS_ABSENT;
                  end else begin
                     point_ctl.op = POP_FLAT;
                  end
               end
               CMD_FLATTEN_ALL: begin
                  point_ctl.op = POP_FLAT_ALL;
               end
               CMD_ADD_EDGE: begin
                  // Height of the first point is being read this cycle.
                  if (!pair_ok) begin
                     status_in = STATUS_ABSENT;
                  end else if (kind_ff == KIND_BAD) begin
                     status_in = STATUS_BAD_KIND;
                  end else if (edge_count >= EDGE_LIMIT) begin
                     status_in = STATUS_FULL;
                  end else begin
                     state_in = S_HEIGHT_A;
                  end
               end
               CMD_QUERY: begin
                  if (!pair_ok) begin
                     status_in = STATUS_ABSENT;
                  end else begin
                     reached_in = '0;
                     reached_in[p_ff] = 1'b1;
                     settled_in = '0;
                     haspred_in = '0;
                     node_we = 1'b1;
                     node_waddr = p_ff;
                     node_wdata.cost = '0;
                     node_wdata.pred = p_ff;
                     scan_cnt_in = '0;
                     pend_in = 1'b0;
                     found_in = 1'b0;
                     state_in = S_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         S_HEIGHT_A: begin
            ha_in = point_rheight;
            point_raddr = q_ff;
            state_in = S_HEIGHT_B;
         end
         S_HEIGHT_B: begin
            edge_append = 1'b1;
            status_in = STATUS_OK;
            state_in = S_RESP;
         end
         S_SCAN: begin
            // Running minimum over the node memory, one node per cycle; strict compare
            // keeps the lowest index among equal distances.
            if (pend_ff && cand && (!found_ff || node_q.cost < min_dist_ff)) begin
               found_in = 1'b1;
               min_dist_in = node_q.cost;
               min_idx_in = pend_idx_ff;
            end
            if (scan_cnt_ff != SCAN_END) begin
               node_raddr = scan_cnt_ff[NODE_W-1:0];
               pend_in = 1'b1;
               pend_idx_in = scan_cnt_ff[NODE_W-1:0];
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else if (!found_ff) begin
               status_in = STATUS_NO_PATH;
               state_in = S_RESP;
            end else begin
               settled_in[min_idx_ff] = 1'b1;
               if (min_idx_ff == q_ff) begin
                  goal_dist_in = min_dist_ff;
                  walk_cur_in = q_ff;
                  route_n_in = '0;
                  state_in = S_WALK_RD;
               end else if (edge_count == '0) begin
                  scan_cnt_in = '0;
                  found_in = 1'b0;
               end else begin
                  eidx_in = '0;
                  state_in = S_EDGE_RD;
               end
            end
         end
         S_EDGE_RD: begin
            state_in = S_EDGE_CHK;
         end
         S_EDGE_CHK: begin
            if (hit_a || hit_b) begin
               node_raddr = v_sel;
               v_in = v_sel;
               state_in = S_NODE_UPD;
            end else begin
               eidx_in = eidx_next;
               if (eidx_next == edge_count) begin
                  scan_cnt_in = '0;
                  found_in = 1'b0;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_EDGE_RD;
               end
            end
         end
         S_NODE_UPD: begin
            // Relaxation: take the new distance when the neighbor is unreached or strictly
            // improved.
            if (!reached_ff[v_ff] || new_dist < node_q.cost) begin
               node_we = 1'b1;
               reached_in[v_ff] = 1'b1;
               haspred_in[v_ff] = 1'b1;
            end
            eidx_in = eidx_next;
            if (eidx_next == edge_count) begin
               scan_cnt_in = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end else begin
               state_in = S_EDGE_RD;
            end
         end
         S_WALK_RD: begin
            route_we = 1'b1;
            route_n_in = route_n_ff + 1'b1;
            if (!haspred_ff[walk_cur_ff] || walk_cur_ff == p_ff || route_n_ff == ROUTE_LAST) begin
               ridx_in = route_n_ff[NODE_W-1:0];
               state_in = S_EMIT_RD;
            end else begin
               state_in = S_WALK_NEXT;
            end
         end
         S_WALK_NEXT: begin
            walk_cur_in = node_q.pred;
            state_in = S_WALK_RD;
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            // The route buffer holds the path goal first, so it is sent from the top down.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_node_in = route_q_ff;
               rsp_dist_in = goal_dist_ff;
               rsp_last_in = (ridx_ff == '0);
               if (ridx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  ridx_in = ridx_ff - 1'b1;
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_node_in = '0;
               rsp_dist_in = '0;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      p_ff <= p_in;
      q_ff <= q_in;
      first_ok_ff <= first_ok_in;
      second_ok_ff <= second_ok_in;
      nh_ff <= nh_in;
      kind_ff <= kind_in;
      status_ff <= status_in;
      ha_ff <= ha_in;
      pend_idx_ff <= pend_idx_in;
      min_dist_ff <= min_dist_in;
      min_idx_ff <= min_idx_in;
      v_ff <= v_in;
      walk_cur_ff <= walk_cur_in;
      goal_dist_ff <= goal_dist_in;
      ridx_ff <= ridx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_node_ff <= rsp_node_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff <= S_IDLE;
         reached_ff <= '0;
         settled_ff <= '0;
         haspred_ff <= '0;
         scan_cnt_ff <= '0;
         pend_ff <= 1'b0;
         found_ff <= 1'b0;
         eidx_ff <= '0;
         route_n_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         reached_ff <= reached_in;
         settled_ff <= settled_in;
         haspred_ff <= haspred_in;
         scan_cnt_ff <= scan_cnt_in;
         pend_ff <= pend_in;
         found_ff <= found_in;
         eidx_ff <= eidx_in;
         route_n_ff <= route_n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (route_we) begin
         route_mem[route_n_ff[NODE_W-1:0]] <= walk_cur_ff;
      end
      route_q_ff <= route_mem[ridx_ff];
   end

   hgsp_point_store u_point_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (point_ctl),
      .wheight (point_wheight),
      .raddr   (point_raddr),
      .rheight (point_rheight),
      .present (point_present)
   );

   hgsp_edge_table #(
      .MAX_EDGES(MAX_EDGES)
   ) u_edge_table (
      .clock   (clock),
      .reset   (reset),
      .append  (edge_append),
      .entry   (edge_entry),
      .raddr   (eidx_ff[EIDX_W-1:0]),
      .entry_q (edge_q),
      .count   (edge_count)
   );

   hgsp_node_mem u_node_mem (
      .clock (clock),
      .we    (node_we),
      .waddr (node_waddr),
      .wdata (node_wdata),
      .raddr (node_raddr),
      .rdata (node_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {2'b00, rsp_dist_ff, rsp_node_ff[2:0], rsp_node_ff[5:3]};
   assign rsp_tuser = rsp_status_ff;
   assign rsp_tlast = rsp_last_ff;

`ifndef SYNTHESIS
   a_settled_reached: assert property (@(posedge clock) disable iff (reset)
      (settled_ff & ~reached_ff) == '0)
      else $error("settled node that was never reached");

   a_pred_reached: assert property (@(posedge clock) disable iff (reset)
      (haspred_ff & ~reached_ff) == '0)
      else $error("predecessor set on an unreached node");

   a_route_bound: assert property (@(posedge clock) disable iff (reset)
      route_n_ff <= SCAN_END)
      else $error("route buffer count beyond node count");

   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && rsp_free) |=> (state_ff == S_IDLE && rsp_tvalid))
      else $error("single result not presented after load");
`endif

endmodule

// ===== rtl/core/hgsp_point_store.sv =====
// Point presence flags and the height memory of the grid.
module hgsp_point_store
   import hgsp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  point_ctl_type          ctl,
   input  logic [HEIGHT_BITS-1:0] wheight,
   input  logic [NODE_W-1:0]      raddr,
   output logic [HEIGHT_BITS-1:0] rheight,
   output logic [NODE_COUNT-1:0]  present
);

   logic [NODE_COUNT-1:0]  present_ff;
   logic [NODE_COUNT-1:0]  flat_ff;
   logic [HEIGHT_BITS-1:0] height_mem [NODE_COUNT];
   logic [HEIGHT_BITS-1:0] height_q_ff;
   logic                   flat_q_ff;

   // A flattened point reads as height zero without touching the memory.
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         flat_ff <= '0;
      end else begin
         case (ctl.op)
            POP_WRITE: begin
               present_ff[ctl.addr] <= 1'b1;
               flat_ff[ctl.addr] <= 1'b0;
            end
            POP_FLAT: begin
               present_ff[ctl.addr] <= 1'b1;
               flat_ff[ctl.addr] <= 1'b1;
            end
            POP_FLAT_ALL: begin
               present_ff <= '1;
               flat_ff <= '1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.op == POP_WRITE) begin
         height_mem[ctl.addr] <= wheight;
      end
      height_q_ff <= height_mem[raddr];
      flat_q_ff <= flat_ff[raddr];
   end

   assign rheight = flat_q_ff ? '0 : height_q_ff;
   assign present = present_ff;

endmodule

// ===== rtl/core/hgsp_edge_table.sv =====
// Edge memory with its fill count; entries are appended in order.
module hgsp_edge_table
   import hgsp_pkg::*;
#(
   parameter int MAX_EDGES = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               append,
   input  edge_entry_type                     entry,
   input  logic [$clog2(MAX_EDGES)-1:0]       raddr,
   output edge_entry_type                     entry_q,
   output logic [$clog2(MAX_EDGES+1)-1:0]     count
);

   localparam int EIDX_W = $clog2(MAX_EDGES);
   localparam int CNT_W = $clog2(MAX_EDGES + 1);

   edge_entry_type     edge_mem [MAX_EDGES];
   edge_entry_type     entry_q_ff;
   logic [CNT_W-1:0]   count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (append) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (append) begin
         edge_mem[count_ff[EIDX_W-1:0]] <= entry;
      end
      entry_q_ff <= edge_mem[raddr];
   end

   assign entry_q = entry_q_ff;
   assign count = count_ff;

endmodule

// ===== rtl/core/hgsp_node_mem.sv =====
// Per-node search memory holding best distance and predecessor.
module hgsp_node_mem
   import hgsp_pkg::*;
(
   input  logic              clock,
   input  logic              we,
   input  logic [NODE_W-1:0] waddr,
   input  node_entry_type    wdata,
   input  logic [NODE_W-1:0] raddr,
   output node_entry_type    rdata
);

   node_entry_type node_mem [NODE_COUNT];
   node_entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         node_mem[waddr] <= wdata;
      end
      rdata_ff <= node_mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== tb/tb.sv =====
// Testbench for the height grid shortest path block: directed and random commands against a predictor.
`timescale 1ns / 1ps

module tb;
   import hgsp_pkg::*;

   // One command item as the testbench builds it, before packing onto the request bus.
   typedef struct {
      cmd_type    cmd;
      logic [2:0] fx;
      logic [2:0] fy;
      logic [2:0] sx;
      logic [2:0] sy;
      logic [7:0] height;
      logic [1:0] kind;
   } command_item_type;

   // One result item, field by field.
   typedef struct {
      status_type status;
      logic [2:0] nx;
      logic [2:0] ny;
      logic [23:0] total;
      logic last;
   } answer_item_type;

   localparam int EDGE_LIMIT = 256;
   localparam logic [23:0] DIST_SAT = 24'hFFFFFF;
   localparam int WATCHDOG_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // first_x[2:0], first_y[5:3], second_x[8:6], second_y[11:9], new_height[19:12],
   // edge_kind[21:20], zero fill[23:22]
   logic [23:0] req_tdata;
   // cmd[2:0]
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // node_x[2:0], node_y[5:3], total_distance[29:6], zero fill[31:30]
   logic [31:0] rsp_tdata;
   // status[2:0]
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   height_grid_shortest_path i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Predictor state: a private copy of the grid and of the edge table.
   logic        grid_present[64];
   logic [7:0]  grid_height[64];
   logic [5:0]  edge_a[EDGE_LIMIT];
   logic [5:0]  edge_b[EDGE_LIMIT];
   logic [23:0] edge_w[EDGE_LIMIT];
   int          edge_total;

   command_item_type pending_commands[$];
   answer_item_type  expected_answers[$];
   int          error_count;
   int          idle_cycles;
   logic        quiet_mode;   // set near the end: no more stalls on either side
   logic        req_accepted; // the item on the bus was taken at the last rising edge
   int          send_gap;
   int          take_gap;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic void queue_answer(input answer_item_type a);
      expected_answers.insert(expected_answers.size(), a);
   endfunction

   function automatic void queue_command(input command_item_type c);
      pending_commands.insert(pending_commands.size(), c);
   endfunction

   // Weight of a new edge from the height step, 8 fraction bits.
   function automatic logic [23:0] edge_cost(input logic [1:0] kind, input int dh);
      longint unsigned n;
      longint unsigned r;
      longint unsigned c;
      if (kind == KIND_WALL) begin
         return 24'((dh + 1) * 256);
      end
      if (kind == KIND_DIAG) begin
         n = 64'd65536 * (64'd1 + 64'(dh) * 64'(dh));
         r = 0;
         for (int k = 31; k >= 0; k--) begin
            c = r | (64'd1 << k);
            if (c * c <= n) begin
               r = c;
            end
         end
         if (n - r * r > r) begin
            r++;
         end
         return 24'(256 + r);
      end
      return 24'((64'd4021238528 * 64'(dh + 1) + 64'd5000000) / 64'd10000000);
   endfunction

   function automatic answer_item_type plain_answer(input status_type st);
      answer_item_type a;
      a.status = st;
      a.nx = 0;
      a.ny = 0;
      a.total = 0;
      a.last = 1'b1;
      return a;
   endfunction

   // Dijkstra from start to goal; settles the lowest index among equal distances.
   task automatic predict_route(input int s, input int g);
      logic [23:0] best[64];
      logic        seen[64];
      logic        done[64];
      logic        linked[64];
      int          from[64];
      int          route[$];
      int          u;
      int          v;
      int          i;
      logic        found;
      longint unsigned nd;
      answer_item_type a;
      for (i = 0; i < 64; i++) begin
         seen[i] = 0;
         done[i] = 0;
         linked[i] = 0;
         best[i] = 0;
         from[i] = 0;
      end
      seen[s] = 1;
      forever begin
         found = 0;
         u = 0;
         for (i = 0; i < 64; i++) begin
            if (seen[i] && !done[i] && (!found || best[i] < best[u])) begin
               u = i;
               found = 1;
            end
         end
         if (!found) break;
         done[u] = 1;
         if (u == g) break;
         for (int e = 0; e < edge_total; e++) begin
            if (edge_a[e] == u) v = edge_b[e];
            else if (edge_b[e] == u) v = edge_a[e];
            else continue;
            nd = 64'(best[u]) + 64'(edge_w[e]);
            if (nd > DIST_SAT) nd = DIST_SAT;
            if (!seen[v] || nd < best[v]) begin
               best[v] = 24'(nd);
               seen[v] = 1;
               from[v] = u;
               linked[v] = 1;
            end
         end
      end
      if (!seen[g]) begin
         queue_answer(plain_answer(STATUS_NO_PATH));
         return;
      end
      i = g;
      while (route.size() < 64) begin
         route.push_front(i);
         if (!linked[i] || i == s) break;
         i = from[i];
      end
      foreach (route[k]) begin
         a.status = STATUS_OK;
         a.nx = 3'(route[k] / 8);
         a.ny = 3'(route[k] % 8);
         a.total = best[g];
         a.last = (k == route.size() - 1);
         queue_answer(a);
      end
   endtask

   // Applies one accepted command to the predictor and queues its results.
   task automatic predict_command(input command_item_type c);
      int p;
      int q;
      int dh;
      p = c.fx * 8 + c.fy;
      q = c.sx * 8 + c.sy;
      case (c.cmd)
         CMD_CREATE: begin
            if (grid_present[p]) begin
               queue_answer(plain_answer(STATUS_EXISTS));
            end else begin
               grid_present[p] = 1;
               grid_height[p] = c.height;
               queue_answer(plain_answer(STATUS_OK));
            end
         end
         CMD_SET_HEIGHT, CMD_FLATTEN: begin
            grid_present[p] = 1;
            grid_height[p] = (c.cmd == CMD_SET_HEIGHT) ? c.height : 8'd0;
            queue_answer(plain_answer(STATUS_OK));
         end
         CMD_FLATTEN_ALL: begin
            for (int i = 0; i < 64; i++) begin
               grid_present[i] = 1;
               grid_height[i] = 0;
            end
            queue_answer(plain_answer(STATUS_OK));
         end
         CMD_ADD_EDGE: begin
            if (!grid_present[p] || !grid_present[q]) begin
               queue_answer(plain_answer(STATUS_ABSENT));
            end else if (c.kind == KIND_BAD) begin
               queue_answer(plain_answer(STATUS_BAD_KIND));
            end else if (edge_total >= EDGE_LIMIT) begin
               queue_answer(plain_answer(STATUS_FULL));
            end else begin
               dh = int'(grid_height[p]) - int'(grid_height[q]);
               if (dh < 0) dh = -dh;
               edge_a[edge_total] = 6'(p);
               edge_b[edge_total] = 6'(q);
               edge_w[edge_total] = edge_cost(c.kind, dh);
               edge_total++;
               queue_answer(plain_answer(STATUS_OK));
            end
         end
         CMD_QUERY: begin
            if (!grid_present[p] || !grid_present[q]) begin
               queue_answer(plain_answer(STATUS_ABSENT));
            end else begin
               predict_route(p, q);
            end
         end
         default: queue_answer(plain_answer(STATUS_OK));
      endcase
   endtask

   function automatic command_item_type make_command(input cmd_type cmd, input int fx,
                                                     input int fy, input int sx, input int sy,
                                                     input int h, input int kind);
      command_item_type c;
      c.cmd = cmd;
      c.fx = 3'(fx);
      c.fy = 3'(fy);
      c.sx = 3'(sx);
      c.sy = 3'(sy);
      c.height = 8'(h);
      c.kind = 2'(kind);
      return c;
   endfunction

   function automatic command_item_type random_command(input cmd_type cmd);
      return make_command(cmd, $urandom_range(7), $urandom_range(7), $urandom_range(7),
                          $urandom_range(7), $urandom_range(255), $urandom_range(3));
   endfunction

   // Driver: presents the oldest pending item, with random bursts of idle cycles.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         // The previous item (if any) was accepted at the last rising edge.
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_commands.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tuser <= pending_commands[0].cmd;
            req_tdata <= {2'b00, pending_commands[0].kind, pending_commands[0].height,
                          pending_commands[0].sy, pending_commands[0].sx,
                          pending_commands[0].fy, pending_commands[0].fx};
            void'(pending_commands.pop_front());
            if (!quiet_mode && $urandom_range(5) == 0) send_gap <= $urandom_range(1, 16);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      // Receiver stalls.
      if (reset || quiet_mode) begin
         rsp_tready <= 1'b1;
         take_gap <= 0;
      end else if (take_gap > 0) begin
         take_gap <= take_gap - 1;
         rsp_tready <= (take_gap == 1);
      end else if ($urandom_range(7) == 0) begin
         take_gap <= $urandom_range(1, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predicts on accepted commands and checks accepted results.
   always @(posedge clock) begin
      answer_item_type want;
      logic moved;
      moved = 1'b0;
      req_accepted <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            predict_command(make_command(cmd_type'(req_tuser), req_tdata[2:0], req_tdata[5:3],
                                         req_tdata[8:6], req_tdata[11:9], req_tdata[19:12],
                                         req_tdata[21:20]));
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            if (expected_answers.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 32'd0);
            end else begin
               want = expected_answers.pop_front();
               if (rsp_tuser != want.status)
                  report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
               if (rsp_tdata[2:0] != want.nx)
                  report_mismatch("node_x", 32'(rsp_tdata[2:0]), 32'(want.nx));
               if (rsp_tdata[5:3] != want.ny)
                  report_mismatch("node_y", 32'(rsp_tdata[5:3]), 32'(want.ny));
               if (rsp_tdata[29:6] != want.total)
                  report_mismatch("total_distance", 32'(rsp_tdata[29:6]), 32'(want.total));
               if (rsp_tlast != want.last)
                  report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
            end
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Stimulus plan. A small set of points gets most of the traffic so that
   // edges connect and queries find real paths.
   initial begin
      int n;
      int cluster;
      command_item_type c;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_CREATE;
      rsp_tready = 1'b1;
      send_gap = 0;
      take_gap = 0;
      quiet_mode = 1'b0;
      error_count = 0;
      idle_cycles = 0;
      edge_total = 0;
      for (int i = 0; i < 64; i++) begin
         grid_present[i] = 0;
         grid_height[i] = 0;
      end

      // Directed part: every command, field extremes and the named corner cases.
      queue_command(make_command(CMD_QUERY, 0, 0, 7, 7, 0, 0));       // both absent
      queue_command(make_command(CMD_ADD_EDGE, 0, 0, 7, 7, 0, 0));    // absent
      queue_command(make_command(CMD_CREATE, 0, 0, 0, 0, 0, 0));
      queue_command(make_command(CMD_CREATE, 0, 0, 0, 0, 255, 0));    // exists
      queue_command(make_command(CMD_CREATE, 7, 7, 7, 7, 255, 3));
      queue_command(make_command(CMD_SET_HEIGHT, 7, 0, 0, 0, 128, 0)); // absent->set
      queue_command(make_command(CMD_FLATTEN, 0, 7, 0, 0, 77, 0));    // absent->flat
      queue_command(make_command(CMD_QUERY, 0, 0, 7, 7, 0, 0));       // no path
      queue_command(make_command(CMD_ADD_EDGE, 0, 0, 7, 7, 0, 3));    // bad kind
      queue_command(make_command(CMD_ADD_EDGE, 0, 0, 7, 0, 0, 0));    // wall
      queue_command(make_command(CMD_ADD_EDGE, 7, 0, 7, 7, 0, 1));    // diagonal
      queue_command(make_command(CMD_ADD_EDGE, 0, 0, 7, 7, 0, 2));    // arc, max dh
      queue_command(make_command(CMD_ADD_EDGE, 0, 7, 0, 7, 0, 0));    // self loop
      queue_command(make_command(CMD_ADD_EDGE, 0, 0, 0, 7, 0, 0));
      queue_command(make_command(CMD_QUERY, 0, 0, 7, 7, 0, 0));
      queue_command(make_command(CMD_QUERY, 7, 7, 0, 7, 0, 0));
      queue_command(make_command(CMD_QUERY, 7, 7, 7, 7, 0, 0));       // start = goal
      queue_command(make_command(CMD_FLATTEN_ALL, 0, 0, 0, 0, 0, 0));
      queue_command(make_command(CMD_QUERY, 0, 0, 7, 7, 0, 0));
      queue_command(make_command(CMD_QUERY, 3, 5, 5, 3, 0, 0));       // no path
      queue_command(make_command(CMD_SET_HEIGHT, 2, 5, 0, 0, 0, 0));

      // Random part: mostly height edits and edges in a small cluster, queries in between.
      n = 0;
      while (n < 95) begin
         cluster = $urandom_range(3);
         case ($urandom_range(9))
            0: c = random_command(CMD_CREATE);
            1: c = random_command(CMD_SET_HEIGHT);
            2: c = random_command(CMD_FLATTEN);
            3, 4, 5: begin
               c = random_command(CMD_ADD_EDGE);
               if (cluster != 0) begin
                  c.fx = 3'($urandom_range(2));
                  c.fy = 3'($urandom_range(2));
                  c.sx = 3'($urandom_range(2));
                  c.sy = 3'($urandom_range(2));
                  if ($urandom_range(7) != 0) c.kind = 2'($urandom_range(2));
               end
            end
            6, 7, 8: begin
               c = random_command(CMD_QUERY);
               if (cluster != 0) begin
                  c.fx = 3'($urandom_range(2));
                  c.fy = 3'($urandom_range(2));
                  c.sx = 3'($urandom_range(2));
                  c.sy = 3'($urandom_range(2));
               end
            end
            default: c = random_command($urandom_range(19) == 0 ? CMD_FLATTEN_ALL : CMD_SET_HEIGHT);
         endcase
         queue_command(c);
         n++;
      end

      // A burst of edges among a few points, then queries over the grown table.
      for (int i = 0; i < 20; i++) begin
         queue_command(make_command(CMD_ADD_EDGE, $urandom_range(1),
                                    $urandom_range(1), $urandom_range(1),
                                    $urandom_range(1), 0, $urandom_range(2)));
      end
      for (int i = 0; i < 4; i++) begin
         queue_command(random_command(CMD_QUERY));
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pending_commands.size() < 30);
      quiet_mode = 1'b1;
      wait (pending_commands.size() == 0 && !req_tvalid);
      wait (expected_answers.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
